>>> design/tcit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcit_pkg;
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] ADDR_CTRL = 2'd0;
   localparam logic [1:0] ADDR_CNT2 = 2'd1;
   localparam logic [1:0] ADDR_CNT1 = 2'd2;
   localparam logic [1:0] ADDR_CNT0 = 2'd3;

   typedef struct packed {
      logic [16:0] count_now;
      logic [15:0] reload_word;
      logic [15:0] latched_word;
      logic        latch_full;
      logic [7:0]  low_byte_hold;
      logic [1:0]  access_mode;
      logic [2:0]  count_mode;
      logic        decimal_flag;
      logic        byte_toggle;
      logic        line_level;
      logic        armed_flag;
      logic        load_pending;
      logic        running_flag;
      logic [2:0]  hold_ticks;
   } counter_type;

   typedef struct packed {
      logic       tick;
      logic       ctrl_wr;
      logic       count_wr;
      logic       rd;
      logic [7:0] data;
   } op_type;

   localparam counter_type COUNTER_RESET = '{
      count_now: 17'd0, reload_word: 16'd0, latched_word: 16'd0, latch_full: 1'b1,
      low_byte_hold: 8'd0, access_mode: 2'd0, count_mode: 3'd0, decimal_flag: 1'b0,
      byte_toggle: 1'b0, line_level: 1'b0, armed_flag: 1'b0, load_pending: 1'b0,
      running_flag: 1'b0, hold_ticks: 3'd0};

   function automatic logic [15:0] bin_to_bcd(input logic [15:0] x);
      logic [15:0] r;
      logic [15:0] v;
      logic [15:0] q;
      r = '0;
      v = x;
      for (int i = 0; i < 4; i++) begin
         q = 16'((32'(v) * 32'd52429) >> 19);
         r[4*i +: 4] = 4'(v - 16'(q * 16'd10));
         v = q;
      end
      return r;
   endfunction

   function automatic logic [15:0] bcd_to_bin(input logic [15:0] x);
      logic [15:0] r;
      logic [3:0]  d;
      r = '0;
      for (int i = 3; i >= 0; i--) begin
         d = x[4*i +: 4];
         if (d > 4'd9) d = 4'd9;
         r = 16'(r * 16'd10) + 16'(d);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

>>> design/tcit_counter.sv
`timescale 1ns / 1ps
`default_nettype none
module tcit_counter (
   input  wire tcit_pkg::counter_type cur,
   input  wire tcit_pkg::op_type      op,
   output tcit_pkg::counter_type      nxt,
   output logic [7:0]                 rdata
);
   tcit_pkg::counter_type t;
   logic signed [18:0] v, rl, span, prev_v, d;
   logic [2:0]  m;
   logic [15:0] rv, wv;
   logic        done;

   always_comb begin
      t = cur;
      rdata = 8'd0;
      done = 1'b0;
      v = 19'(cur.count_now);
      rl = 19'(cur.reload_word);
      span = cur.decimal_flag ? 19'sd10000 : 19'sd65536;
      prev_v = '0;
      d = 19'sd2;
      m = op.data[3:1];
      rv = '0;
      wv = '0;
      if (op.tick || op.ctrl_wr) begin
         if (t.hold_ticks != 3'd0) begin
            t.hold_ticks = t.hold_ticks - 3'd1;
         end else if (t.running_flag || t.load_pending) begin
            unique case (t.count_mode)
               3'd0: begin
                  if (t.load_pending) begin
                     v = rl;
                     t.running_flag = 1'b1;
                     t.armed_flag = 1'b1;
                     t.line_level = 1'b0;
                  end
                  prev_v = v;
                  v = v - 19'sd1;
                  if (v <= 0) begin
                     if (t.armed_flag && prev_v != 0) begin
                        t.line_level = 1'b1;
                        t.armed_flag = 1'b0;
                     end
                     v = v + span;
                  end
               end
               3'd1: begin
                  t.running_flag = 1'b1;
                  v = v - 19'sd1;
                  if (v <= 0) v = v + ((rl == 0) ? span : rl + 19'sd1);
               end
               3'd2, 3'd3: begin
                  if (!t.running_flag) begin
                     v = rl;
                     t.running_flag = 1'b1;
                  end
                  if (t.count_mode == 3'd2) begin
                     v = v - 19'sd1;
                     if (v <= 0) v = v + ((rl == 0) ? span : rl);
                  end else begin
                     if (v == rl && v[0]) d = t.line_level ? 19'sd1 : 19'sd3;
                     v = v - d;
                     if (v <= 0) begin
                        t.line_level = ~t.line_level;
                        v = v + ((rl == 0) ? span : rl);
                     end
                  end
               end
               default: ;
            endcase
            if (v < 0) v = '0;
            t.count_now = v[16:0];
            t.load_pending = 1'b0;
         end
      end
      if (op.ctrl_wr) begin
         t.hold_ticks = 3'd1;
         if (op.data[5:4] == 2'd0) begin
            t.latched_word = t.count_now[15:0];
            t.latch_full = 1'b1;
         end else begin
            t.decimal_flag = op.data[0];
            if (m[1]) m = {1'b0, m[1:0]};
            t.count_mode = m;
            if (m == 3'd0) begin
               t.line_level = 1'b0;
               t.armed_flag = 1'b1;
            end else begin
               t.line_level = 1'b1;
               if (m == 3'd1) t.armed_flag = 1'b1;
            end
            t.running_flag = 1'b0;
            t.load_pending = 1'b0;
            t.access_mode = op.data[5:4];
            t.byte_toggle = 1'b0;
         end
      end
      if (op.count_wr) begin
         unique case (t.access_mode)
            2'd3: begin
               if (!t.byte_toggle) begin
                  t.low_byte_hold = op.data;
                  t.byte_toggle = 1'b1;
               end else begin
                  wv = {op.data, t.low_byte_hold};
                  t.byte_toggle = 1'b0;
                  done = 1'b1;
               end
            end
            2'd1: begin
               wv = {8'd0, op.data};
               done = 1'b1;
            end
            2'd2: begin
               wv = {op.data, 8'd0};
               t.count_now = {1'b0, wv};
               done = 1'b1;
            end
            default: ;
         endcase
         if (done) begin
            t.load_pending = 1'b1;
            t.reload_word = t.decimal_flag ? tcit_pkg::bcd_to_bin(wv) : wv;
            if (t.count_mode == 3'd0) t.hold_ticks = 3'd3;
            else if (t.count_mode <= 3'd3) begin
               if (!t.running_flag) t.hold_ticks = 3'd3;
            end else t.hold_ticks = 3'd4;
         end
      end
      if (op.rd && t.access_mode != 2'd0) begin
         rv = t.latch_full ? t.latched_word : t.count_now[15:0];
         if (t.decimal_flag) rv = tcit_pkg::bin_to_bcd(rv);
         unique case (t.access_mode)
            2'd1: begin
               t.latch_full = 1'b0;
               rdata = rv[7:0];
            end
            2'd2: begin
               t.latch_full = 1'b0;
               rdata = rv[15:8];
            end
            default: begin
               if (!t.byte_toggle) begin
                  t.byte_toggle = 1'b1;
                  rdata = rv[7:0];
               end else begin
                  t.latch_full = 1'b0;
                  t.byte_toggle = 1'b0;
                  rdata = rv[15:8];
               end
            end
         endcase
      end
      nxt = t;
   end
endmodule
`default_nettype wire

>>> design/three_channel_interval_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_cmd, req_addr, req_wdata
// rsp      out        rsp_valid, rsp_ready, rsp_rdata, rsp_out_zero, rsp_out_one, rsp_out_two
// One transaction is taken per cycle while req_ready is high; its result appears next cycle.
// The counter update is one pass of combinational logic per counter.
// Reset clears all counters; latch_full comes out of reset set.
// A result held by a stalled rsp channel stops req only when it cannot move.
module three_channel_interval_timer #(
   parameter int NUM_COUNTERS = 3
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [1:0] req_cmd,
   input  wire  [1:0] req_addr,
   input  wire  [7:0] req_wdata,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [7:0] rsp_rdata,
   output logic       rsp_out_zero,
   output logic       rsp_out_one,
   output logic       rsp_out_two
);
   tcit_pkg::counter_type cnt_ff [3];
   tcit_pkg::counter_type cnt_in [3];
   tcit_pkg::op_type      op     [3];
   logic [7:0] rd        [3];
   logic [7:0] ctrl_ff;
   logic [7:0] rdata_ff, rdata_in;
   logic       valid_ff;
   logic       take;

   assign req_ready = !valid_ff || rsp_ready;
   assign take = req_valid && req_ready;

   for (genvar c = 0; c < 3; c++) begin : g_cnt
      always_comb begin
         op[c].tick = take && req_cmd == tcit_pkg::CMD_TICK && c < NUM_COUNTERS;
         op[c].ctrl_wr = take && req_cmd == tcit_pkg::CMD_WRITE
                         && req_addr == tcit_pkg::ADDR_CTRL
                         && req_wdata[7:6] == 2'(c) && c < NUM_COUNTERS;
         op[c].count_wr = take && req_cmd == tcit_pkg::CMD_WRITE
                          && req_addr == 2'(3 - c) && c < NUM_COUNTERS;
         op[c].rd = take && req_cmd == tcit_pkg::CMD_READ
                    && req_addr == 2'(3 - c) && c < NUM_COUNTERS;
         op[c].data = req_wdata;
      end
      tcit_counter u_cnt (.cur(cnt_ff[c]), .op(op[c]), .nxt(cnt_in[c]), .rdata(rd[c]));
      always_ff @(posedge clock) begin
         if (reset) cnt_ff[c] <= tcit_pkg::COUNTER_RESET;
         else cnt_ff[c] <= cnt_in[c];
      end
   end

   always_comb begin
      rdata_in = rd[0] | rd[1] | rd[2];
      if (req_cmd == tcit_pkg::CMD_READ && req_addr == tcit_pkg::ADDR_CTRL) rdata_in = ctrl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctrl_ff <= 8'd0;
      end else begin
         if (take) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
         if (take && req_cmd == tcit_pkg::CMD_WRITE && req_addr == tcit_pkg::ADDR_CTRL)
            ctrl_ff <= req_wdata;
      end
      if (take) rdata_ff <= rdata_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_rdata = rdata_ff;
   assign rsp_out_zero = cnt_ff[0].line_level;
   assign rsp_out_one = cnt_ff[1].line_level;
   assign rsp_out_two = cnt_ff[2].line_level;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rdata))
      else $error("result changed while stalled");
   a_no_take_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(rsp_out_zero) && $stable(rsp_out_one) && $stable(rsp_out_two))
      else $error("output line moved without a transaction");
endmodule
`default_nettype wire

>>> bench/tcit_checker.sv
`timescale 1ns / 1ps
module tcit_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_ready,
   input  wire  [1:0] req_cmd,
   input  wire  [1:0] req_addr,
   input  wire  [7:0] req_wdata,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire  [7:0] rsp_rdata,
   input  wire        rsp_out_zero,
   input  wire        rsp_out_one,
   input  wire        rsp_out_two,
   output int         fail_count,
   output int         pending_results
);
   typedef struct packed {
      logic [7:0] rdata;
      logic       line0;
      logic       line1;
      logic       line2;
   } timer_result_type;

   logic [16:0] cnt [3];
   logic [15:0] reload [3];
   logic [15:0] latched [3];
   logic        latch_full [3];
   logic [7:0]  low_hold [3];
   logic [1:0]  access [3];
   logic [2:0]  mode [3];
   logic        bcd [3];
   logic        toggle [3];
   logic        line [3];
   logic        armed [3];
   logic        pending [3];
   logic        running [3];
   logic [2:0]  hold [3];
   logic [7:0]  ctrl_copy;
   timer_result_type expected_results [$];

   function automatic logic [15:0] to_bcd(input logic [15:0] x);
      logic [15:0] r;
      int v;
      r = '0;
      v = x;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = 4'(v % 10);
         v = v / 10;
      end
      return r;
   endfunction

   function automatic logic [15:0] from_bcd(input logic [15:0] x);
      int r;
      int d;
      r = 0;
      for (int i = 3; i >= 0; i--) begin
         d = x[4*i +: 4];
         if (d > 9) d = 9;
         r = r * 10 + d;
      end
      return 16'(r);
   endfunction

   task automatic tick_counter(input int c);
      int v;
      int rl;
      int span;
      int prior;
      int d;
      v = cnt[c];
      rl = reload[c];
      span = bcd[c] ? 10000 : 65536;
      if (hold[c] != 0) begin
         hold[c] = hold[c] - 1;
         return;
      end
      if (!running[c] && !pending[c]) return;
      case (mode[c])
         3'd0: begin
            if (pending[c]) begin
               v = rl;
               running[c] = 1;
               armed[c] = 1;
               line[c] = 0;
            end
            if (running[c]) begin
               prior = v;
               v = v - 1;
               if (v <= 0) begin
                  if (armed[c] && prior != 0) begin
                     line[c] = 1;
                     armed[c] = 0;
                  end
                  v = v + span;
               end
            end
         end
         3'd1: begin
            if (!running[c] && pending[c]) running[c] = 1;
            if (running[c]) begin
               v = v - 1;
               if (v <= 0) v = v + ((rl == 0) ? span : rl + 1);
            end
         end
         3'd2, 3'd3: begin
            if (!running[c] && pending[c]) begin
               v = rl;
               running[c] = 1;
            end
            if (running[c]) begin
               if (mode[c] == 3'd2) begin
                  v = v - 1;
                  if (v <= 0) v = v + ((rl == 0) ? span : rl);
               end else begin
                  d = 2;
                  if (v == rl && v[0]) d = line[c] ? 1 : 3;
                  v = v - d;
                  if (v <= 0) begin
                     line[c] = !line[c];
                     v = v + ((rl == 0) ? span : rl);
                  end
               end
            end
         end
         default: ;
      endcase
      if (v < 0) v = 0;
      cnt[c] = 17'(v);
      pending[c] = 0;
   endtask

   task automatic write_control(input logic [7:0] data);
      int c;
      logic [1:0] rw;
      logic [2:0] m;
      c = data[7:6];
      rw = data[5:4];
      m = data[3:1];
      ctrl_copy = data;
      if (c == 3) return;
      tick_counter(c);
      hold[c] = 1;
      if (rw == 2'd0) begin
         latched[c] = cnt[c][15:0];
         latch_full[c] = 1;
         return;
      end
      bcd[c] = data[0];
      if (m[1:0] == 2'd2) m = 3'd2;
      else if (m[1:0] == 2'd3) m = 3'd3;
      mode[c] = m;
      if (m == 3'd0) begin
         line[c] = 0;
         armed[c] = 1;
      end else begin
         line[c] = 1;
         if (m == 3'd1) armed[c] = 1;
      end
      running[c] = 0;
      pending[c] = 0;
      access[c] = rw;
      toggle[c] = 0;
   endtask

   task automatic write_count(input int c, input logic [7:0] data);
      logic done;
      done = 0;
      case (access[c])
         2'd3: begin
            if (!toggle[c]) begin
               low_hold[c] = data;
               toggle[c] = 1;
            end else begin
               reload[c] = {data, low_hold[c]};
               toggle[c] = 0;
               done = 1;
            end
         end
         2'd1: begin
            reload[c] = {8'd0, data};
            done = 1;
         end
         2'd2: begin
            reload[c] = {data, 8'd0};
            cnt[c] = {1'b0, data, 8'd0};
            done = 1;
         end
         default: ;
      endcase
      if (!done) return;
      pending[c] = 1;
      if (bcd[c]) reload[c] = from_bcd(reload[c]);
      if (mode[c] == 3'd0) hold[c] = 3;
      else if (mode[c] <= 3'd3) begin
         if (!running[c]) hold[c] = 3;
      end else hold[c] = 4;
   endtask

   function automatic logic [7:0] read_count(input int c);
      logic [15:0] v;
      if (access[c] == 2'd0) return 8'd0;
      v = latch_full[c] ? latched[c] : cnt[c][15:0];
      if (bcd[c]) v = to_bcd(v);
      if (access[c] == 2'd1) begin
         latch_full[c] = 0;
         return v[7:0];
      end
      if (access[c] == 2'd2) begin
         latch_full[c] = 0;
         return v[15:8];
      end
      if (!toggle[c]) begin
         toggle[c] = 1;
         return v[7:0];
      end
      latch_full[c] = 0;
      toggle[c] = 0;
      return v[15:8];
   endfunction

   task automatic predict_item(input logic [1:0] cmd, input logic [1:0] addr,
                               input logic [7:0] data);
      timer_result_type r;
      int c;
      c = 3 - addr;
      r = '0;
      if (cmd == tcit_pkg::CMD_WRITE) begin
         if (addr == tcit_pkg::ADDR_CTRL) write_control(data);
         else write_count(c, data);
      end else if (cmd == tcit_pkg::CMD_READ) begin
         if (addr == tcit_pkg::ADDR_CTRL) r.rdata = ctrl_copy;
         else r.rdata = read_count(c);
      end else if (cmd == tcit_pkg::CMD_TICK) begin
         for (int i = 0; i < 3; i++) tick_counter(i);
      end
      r.line0 = line[0];
      r.line1 = line[1];
      r.line2 = line[2];
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      timer_result_type e;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cnt[i] = '0; reload[i] = '0; latched[i] = '0; latch_full[i] = 1;
            low_hold[i] = '0; access[i] = '0; mode[i] = '0; bcd[i] = 0;
            toggle[i] = 0; line[i] = 0; armed[i] = 0; pending[i] = 0;
            running[i] = 0; hold[i] = '0;
         end
         ctrl_copy = '0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result rdata=%h", $time, rsp_rdata);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (e.rdata !== rsp_rdata || e.line0 !== rsp_out_zero ||
                   e.line1 !== rsp_out_one || e.line2 !== rsp_out_two) begin
                  $display({"%0t: mismatch expected rdata=%h lines=%b%b%b",
                            " actual rdata=%h lines=%b%b%b"},
                           $time, e.rdata, e.line2, e.line1, e.line0, rsp_rdata,
                           rsp_out_two, rsp_out_one, rsp_out_zero);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_item(req_cmd, req_addr, req_wdata);
      end
      pending_results = expected_results.size();
   end
endmodule

>>> bench/tb_three_channel_interval_timer.sv
`timescale 1ns / 1ps
module tb_three_channel_interval_timer;
   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_cmd = tcit_pkg::CMD_TICK;
   logic [1:0] req_addr = '0;
   logic [7:0] req_wdata = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_rdata;
   logic       rsp_out_zero, rsp_out_one, rsp_out_two;
   int         fail_count;
   int         pending_results;
   int         cycle_count = 0;

   localparam int CYCLE_LIMIT = 200000;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   three_channel_interval_timer dut (.*);

   tcit_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("three_channel_interval_timer verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      int phase;
      phase = cycle_count % 64;
      if (phase < 16) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   int gap_left = 0;
   int burst_left = 0;

   task automatic send_item(input logic [1:0] cmd, input logic [1:0] addr,
                            input logic [7:0] data);
      if (burst_left == 0 && gap_left > 0) begin
         req_valid <= 0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_addr <= addr;
      req_wdata <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic program_counter(input int c, input logic [2:0] m, input logic [1:0] rw,
                                  input logic bcd_on);
      send_item(tcit_pkg::CMD_WRITE, tcit_pkg::ADDR_CTRL, {2'(c), rw, m, bcd_on});
   endtask

   initial begin
      logic [1:0] a;
      logic [1:0] rw;
      int c;
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(tcit_pkg::CMD_READ, tcit_pkg::ADDR_CNT0, 8'h00);
      send_item(tcit_pkg::CMD_WRITE, tcit_pkg::ADDR_CNT1, 8'h55);
      send_item(tcit_pkg::CMD_WRITE, tcit_pkg::ADDR_CTRL, 8'hFF);
      send_item(tcit_pkg::CMD_READ, tcit_pkg::ADDR_CTRL, 8'h00);
      send_item(tcit_pkg::CMD_NONE, tcit_pkg::ADDR_CNT2, 8'hAA);
      for (int m = 0; m < 8; m++) begin
         program_counter(m % 3, 3'(m), 2'd3, m[0]);
         send_item(tcit_pkg::CMD_WRITE, 2'(3 - m % 3), 8'h03);
         send_item(tcit_pkg::CMD_WRITE, 2'(3 - m % 3), (m == 7) ? 8'hFF : 8'h00);
         repeat (6) send_item(tcit_pkg::CMD_TICK, tcit_pkg::ADDR_CTRL, 8'h00);
      end
      program_counter(0, 3'd2, 2'd0, 0);
      send_item(tcit_pkg::CMD_READ, tcit_pkg::ADDR_CNT0, 8'h00);
      send_item(tcit_pkg::CMD_READ, tcit_pkg::ADDR_CNT0, 8'h00);
      for (int i = 0; i < 1550; ) begin
         c = $urandom_range(0, 2);
         a = 2'(3 - c);
         if ($urandom_range(0, 3) != 0) begin
            rw = 2'($urandom_range(1, 3));
            program_counter(c, 3'($urandom_range(0, 7)), rw, 1'($urandom_range(0, 1)));
            send_item(tcit_pkg::CMD_WRITE, a, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                      8'($urandom_range(0, 12)));
            if (rw == 2'd3) send_item(tcit_pkg::CMD_WRITE, a,
                                      ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00);
            n = $urandom_range(4, 40);
            i += n + 3;
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0: send_item(tcit_pkg::CMD_READ, 2'($urandom), 8'($urandom));
                  1: send_item(tcit_pkg::CMD_WRITE, tcit_pkg::ADDR_CTRL,
                               {2'($urandom), 2'b00, 4'($urandom)});
                  2: send_item(2'($urandom), 2'($urandom), 8'($urandom));
                  default: send_item(tcit_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
               endcase
            end
         end else begin
            send_item(2'($urandom), 2'($urandom), 8'($urandom));
            i++;
         end
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("three_channel_interval_timer verification clean");
      else $display("three_channel_interval_timer verification failed");
      $finish;
   end
endmodule
